[rtl/dmcrc_pkg.sv]
// Package for the dual-mode CRC byte engine: polynomials, initial values,
// the byte fold function and the request struct between stages. No dependencies.
package dmcrc_pkg;

  localparam logic [31:0] POLY16 = 32'h0000_A001;
  localparam logic [31:0] POLY32 = 32'hEDB8_8320;
  localparam logic [31:0] INIT16 = 32'h0000_0000;
  localparam logic [31:0] INIT32 = 32'hFFFF_FFFF;
  localparam logic [31:0] MASK16 = 32'h0000_FFFF;

  localparam logic MODE_CRC16 = 1'b0;
  localparam logic MODE_CRC32 = 1'b1;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } dmcrc_req_t;

  // one byte of reflected CRC, LSB first, eight shift/xor steps
  function automatic logic [31:0] fold_byte(input logic [31:0] crc,
                                            input logic [7:0]  data,
                                            input logic [31:0] poly);
    logic [31:0] c;
    c = crc ^ {24'h0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ poly;
      else      c = c >> 1;
    end
    return c;
  endfunction

  function automatic logic [31:0] mode_init(input logic mode);
    return (mode == MODE_CRC32) ? INIT32 : INIT16;
  endfunction

endpackage

[rtl/dmcrc_in_stage.sv]
// Input register for the CRC engine; holds one request until the update stage takes it.
// Depends on dmcrc_pkg.
module dmcrc_in_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_byte,
  input  logic                  take,
  output dmcrc_pkg::dmcrc_req_t req
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       last_r;
  logic       load;

  assign in_stall = valid_r & ~take;
  assign load     = in_valid & ~in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load)      valid_nxt = 1'b1;
    else if (take) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  assign req.valid = valid_r;
  assign req.data  = data_r;
  assign req.last  = last_r;

endmodule

[rtl/dmcrc_fold.sv]
// Combinational byte update for both CRC widths.
// Depends on dmcrc_pkg.
module dmcrc_fold (
  input  logic        mode,
  input  logic [31:0] crc,
  input  logic [7:0]  data,
  output logic [31:0] crc_nxt
);

  logic [31:0] f16, f32;

  assign f32 = dmcrc_pkg::fold_byte(crc, data, dmcrc_pkg::POLY32);
  assign f16 = dmcrc_pkg::fold_byte(crc & dmcrc_pkg::MASK16, data, dmcrc_pkg::POLY16)
               & dmcrc_pkg::MASK16;

  assign crc_nxt = (mode == dmcrc_pkg::MODE_CRC32) ? f32 : f16;

endmodule

[rtl/dual_mode_crc_byte_engine_unit.sv]
// Dual-mode CRC byte engine: input register, running CRC update, result register.
// Result path: the last byte waits in the input register, is folded, and its CRC is loaded into the result register.
// Throughput: one byte per cycle; only a stalled result with a pending last byte holds input.
// Reset (sync, active low): mode = CRC-32, running CRC = 0xFFFFFFFF, all requests dropped.
// Depends on dmcrc_pkg, dmcrc_in_stage, dmcrc_fold.
module dual_mode_crc_byte_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_crc_mode,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_crc_value
);

  dmcrc_pkg::dmcrc_req_t req;

  logic        mode_r, mode_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_crc_r;
  logic [31:0] fold_out;
  logic        out_free;
  logic        take;
  logic        emit;

  assign out_free = ~out_valid_r | ~out_stall;
  assign take     = req.valid & (~req.last | out_free);
  assign emit     = take & req.last;

  dmcrc_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .take         (take),
    .req          (req)
  );

  dmcrc_fold u_fold (
    .mode    (mode_r),
    .crc     (crc_r),
    .data    (req.data),
    .crc_nxt (fold_out)
  );

  always_comb begin
    mode_nxt      = mode_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (cfg_wr_en) begin
      // mode write aborts any message in progress
      mode_nxt = cfg_crc_mode;
      crc_nxt  = dmcrc_pkg::mode_init(cfg_crc_mode);
    end else if (take) begin
      crc_nxt = req.last ? dmcrc_pkg::mode_init(mode_r) : fold_out;
    end
    if (emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= dmcrc_pkg::MODE_CRC32;
      crc_r       <= dmcrc_pkg::INIT32;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_crc_r <= fold_out;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

endmodule

[rtl/dmcrc_checker.sv]
// Port-level checks for the dual-mode CRC engine, bound to the top level.
// Depends on dmcrc_pkg and dual_mode_crc_byte_engine_unit.
module dmcrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_wr_en,
  input logic        cfg_crc_mode,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_crc_value
);

  // mirror of the mode register as seen on the config port
  logic mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= dmcrc_pkg::MODE_CRC32;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_crc_mode;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_crc_value))
    else $error("stalled result changed or dropped");

  a_stall_only_on_backup: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side is free");

  a_crc16_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (mode_r == dmcrc_pkg::MODE_CRC16) |-> out_crc_value[31:16] == 16'h0000)
    else $error("CRC-16 result has nonzero upper half");

endmodule

bind dual_mode_crc_byte_engine_unit dmcrc_checker u_dmcrc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .cfg_wr_en     (cfg_wr_en),
  .cfg_crc_mode  (cfg_crc_mode),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_crc_value (out_crc_value)
);

[tb/testbench.sv]
// Self-checking bench for dual_mode_crc_byte_engine_unit: random byte messages in both modes,
// a scoreboard class that folds every accepted request and checks each finished CRC.
// Depends on dmcrc_pkg and the engine RTL.
`timescale 1ns / 100ps

module testbench;

  class crc_scoreboard;
    logic        mode;
    logic [31:0] crc_acc;
    logic [31:0] crc_q[$];
    int          n_errors;

    function new();
      mode = dmcrc_pkg::MODE_CRC32;
      crc_acc = dmcrc_pkg::INIT32;
      n_errors = 0;
    endfunction

    // any mode write drops the message in progress
    function void reload(logic m);
      mode = m;
      crc_acc = (m == dmcrc_pkg::MODE_CRC32) ? dmcrc_pkg::INIT32 : dmcrc_pkg::INIT16;
    endfunction

    // bit-serial reflected CRC, one data bit per step
    function logic [31:0] crc_bits(logic [31:0] c, logic [7:0] b, logic [31:0] poly);
      logic fb;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c = {1'b0, c[31:1]} ^ (fb ? poly : 32'h0);
      end
      return c;
    endfunction

    function int pending();
      return crc_q.size();
    endfunction

    task report(string msg);
      n_errors++;
      $display("%0t: mismatch: %s", $time, msg);
    endtask

    task note_request(logic [7:0] b, logic last);
      logic [31:0] nxt;
      if (mode == dmcrc_pkg::MODE_CRC32) begin
        nxt = crc_bits(crc_acc, b, dmcrc_pkg::POLY32);
      end else begin
        nxt = crc_bits(crc_acc & dmcrc_pkg::MASK16, b, dmcrc_pkg::POLY16) & dmcrc_pkg::MASK16;
      end
      if (last) begin
        crc_q.push_back(nxt);
        reload(mode);
      end else begin
        crc_acc = nxt;
      end
    endtask

    task check_result(logic [31:0] got);
      logic [31:0] want;
      if (crc_q.size() == 0) begin
        report($sformatf("unexpected result crc_value=%08h", got));
      end else begin
        want = crc_q.pop_front();
        if (got !== want)
          report($sformatf("crc_value got %08h, expected %08h", got, want));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_crc_mode = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_crc_value;

  crc_scoreboard sb = new();
  bit tx_eager = 1'b0;
  bit rx_eager = 1'b0;
  int hold_len = 0;

  dual_mode_crc_byte_engine_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_crc_mode(cfg_crc_mode),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_crc_value(out_crc_value)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // monitor: mode writes, accepted requests and accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) sb.reload(cfg_crc_mode);
      if (in_valid && in_stall === 1'b0) sb.note_request(in_data_byte, in_last_byte);
      if (out_valid === 1'b1 && !out_stall) sb.check_result(out_crc_value);
    end
  end

  // result side: random stall before each result, plus a single long hold-off
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      n = rx_eager ? 0 : $urandom_range(0, 17);
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
      end
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= lst;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_byte(pick_byte(), i == len - 1);
  endtask

  // sender pauses until every expected CRC is back and the pipe is empty
  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_crc_mode <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic modes[6];
    int sent;
    int len;
    modes = '{dmcrc_pkg::MODE_CRC16, dmcrc_pkg::MODE_CRC16, dmcrc_pkg::MODE_CRC32,
              dmcrc_pkg::MODE_CRC32, dmcrc_pkg::MODE_CRC16, dmcrc_pkg::MODE_CRC32};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset mode is CRC-32, extremes and the check string
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    for (int i = 1; i <= 9; i++) send_byte(8'h30 + 8'(i), i == 9);
    // partial message aborted by writing the same mode
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h80, 1'b0);
    write_mode(dmcrc_pkg::MODE_CRC32);
    send_byte(8'hFF, 1'b1);
    write_mode(dmcrc_pkg::MODE_CRC16);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    for (int i = 1; i <= 9; i++) send_byte(8'h30 + 8'(i), i == 9);

    // random phases; odd phases leave a message open across the mode write
    for (int p = 0; p < 6; p++) begin
      write_mode(modes[p]);
      tx_eager = (p == 2 || p == 3);
      rx_eager = (p == 2);
      if (p == 3) hold_len = 300;
      sent = 0;
      while (sent < 200) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
        send_message(len);
        sent += len;
      end
      if (p % 2 == 1) begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) send_byte(pick_byte(), 1'b0);
      end
    end
    tx_eager = 1'b0;
    rx_eager = 1'b0;
    send_message(7);

    drain();
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected CRC results never arrived", sb.pending()));
    if (sb.n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
